// File: rtl/voxel_face_cull_ambient_occlusion_defines.svh
// Assertion macros shared by the RTL files of the voxel face culling block.
// Both macros expect a signal named clk, and VFC_ASSERT also rst_n, in the module that uses them.
`ifndef VOXEL_FACE_CULL_AMBIENT_OCCLUSION_DEFINES_SVH
`define VOXEL_FACE_CULL_AMBIENT_OCCLUSION_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every clock edge while the block is out of reset.
`define VFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("voxel face cull: assertion failed");

// Checked at every clock edge, including during reset.
`define VFC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("voxel face cull: reset assertion failed");

`else

`define VFC_ASSERT(label, prop)
`define VFC_ASSERT_RST(label, prop)

`endif

`endif

// File: rtl/vfcao_pkg.sv
`default_nettype none

package vfcao_pkg;

  localparam int FACE_NUM   = 6;
  localparam int CORNER_NUM = 4;
  localparam int RING_NUM   = 8;
  localparam int NB_W       = 27;
  localparam int WEIGHT_W   = 10;

  // Face codes in visiting order.
  typedef enum logic [2:0] {
    FACE_TOP    = 3'd0,
    FACE_BOTTOM = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_FRONT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_t;

  typedef logic [NB_W-1:0]       nb_t;
  typedef logic [4:0]            nb_idx_t;
  typedef logic [2:0]            ring_idx_t;
  typedef logic [1:0]            level_t;
  typedef logic [FACE_NUM-1:0]   face_mask_t;
  typedef logic [RING_NUM-1:0]   ring_t;

  typedef level_t [CORNER_NUM-1:0] face_lv_t;
  typedef face_lv_t [FACE_NUM-1:0] all_lv_t;

  typedef struct packed {
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] z;
    logic [7:0] vtype;
  } vox_t;

  // After culling: which faces are exposed, plus the raw neighbor mask.
  typedef struct packed {
    vox_t       vox;
    face_mask_t exposed;
    nb_t        nb;
  } s1_t;

  // After corner levels.
  typedef struct packed {
    vox_t       vox;
    face_mask_t exposed;
    all_lv_t    levels;
  } s2_t;

  // After the diagonal split decision.
  typedef struct packed {
    vox_t       vox;
    face_mask_t exposed;
    all_lv_t    levels;
    face_mask_t split;
  } s3_t;

  // Neighbor bit directly across each face.
  localparam nb_idx_t DIRECT_BIT [FACE_NUM] = '{
    5'd22, 5'd4, 5'd12, 5'd14, 5'd10, 5'd16
  };

  // Ring of eight neighbors in the outer layer of each face.
  localparam nb_idx_t RING_BIT [FACE_NUM][RING_NUM] = '{
    '{5'd24, 5'd25, 5'd26, 5'd23, 5'd20, 5'd19, 5'd18, 5'd21},
    '{5'd0,  5'd1,  5'd2,  5'd5,  5'd8,  5'd7,  5'd6,  5'd3},
    '{5'd24, 5'd21, 5'd18, 5'd9,  5'd0,  5'd3,  5'd6,  5'd15},
    '{5'd20, 5'd23, 5'd26, 5'd17, 5'd8,  5'd5,  5'd2,  5'd11},
    '{5'd18, 5'd19, 5'd20, 5'd11, 5'd2,  5'd1,  5'd0,  5'd9},
    '{5'd26, 5'd25, 5'd24, 5'd15, 5'd6,  5'd7,  5'd8,  5'd17}
  };

  // Ring positions of side, corner and other side for each vertex.
  localparam ring_idx_t CORNER_SEL [CORNER_NUM][3] = '{
    '{3'd7, 3'd6, 3'd5},
    '{3'd5, 3'd4, 3'd3},
    '{3'd3, 3'd2, 3'd1},
    '{3'd1, 3'd0, 3'd7}
  };

  // Brightness weights in thousandths for levels 0 to 3.
  localparam logic [WEIGHT_W-1:0] LEVEL_WEIGHT [4] = '{
    10'd512, 10'd640, 10'd800, 10'd1000
  };

  // Gather the ring of one face from the neighbor mask.
  function automatic ring_t ring_of(input nb_t nb, input int face);
    ring_t r;
    for (int i = 0; i < RING_NUM; i++) begin
      r[i] = nb[RING_BIT[face][i]];
    end
    return r;
  endfunction

  // Occlusion level of one vertex: zero when both sides are opaque.
  function automatic level_t corner_level(input ring_t ring, input int k);
    logic   s1;
    logic   cn;
    logic   s2;
    level_t cnt;
    s1  = ring[CORNER_SEL[k][0]];
    cn  = ring[CORNER_SEL[k][1]];
    s2  = ring[CORNER_SEL[k][2]];
    cnt = level_t'(s1) + level_t'(s2) + level_t'(cn);
    if (s1 && s2) begin
      return '0;
    end
    return 2'd3 - cnt;
  endfunction

  // Diagonal split: weights of vertices 0 and 2 against 1 and 3.
  function automatic logic split_of(input face_lv_t lv);
    logic [WEIGHT_W:0] a;
    logic [WEIGHT_W:0] b;
    a = {1'b0, LEVEL_WEIGHT[lv[0]]} + {1'b0, LEVEL_WEIGHT[lv[2]]};
    b = {1'b0, LEVEL_WEIGHT[lv[1]]} + {1'b0, LEVEL_WEIGHT[lv[3]]};
    return a > b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/voxel_face_cull_ambient_occlusion.sv
`default_nettype none

// Voxel face culling with ambient occlusion.
// Input channel (in_valid/in_ready): one voxel per transfer with its position,
// type and the 27-bit opacity mask of its neighbors. Output channel
// (out_valid/out_ready): one quad per transfer, faces in the order top, bottom,
// left, right, front, back, with out_last_quad set on the voxel's final quad.
// A voxel of the empty type, or one enclosed on all six sides, gives no quad.
// Configuration channel (cfg_valid/cfg_ready): writes the empty type code;
// it is always ready; the user must write it only while the block is idle.
// The block itself does not enforce this. An input transfer loads the first
// of three pipeline stages (culling, levels, split); the quad hold and the
// output register follow.
// Throughput: while in_ready is high one voxel per cycle enters the pipeline;
// while out_ready is high the output register sends one quad per cycle, up to
// 6 per voxel; voxels follow without a gap unless a faceless one comes between.
// When the receiver stalls, the output register holds its quad and the stall
// backs up stage by stage to in_ready; nothing is lost or repeated.
// Synchronous reset empties every stage and sets the empty type code to 0.
module voxel_face_cull_ambient_occlusion (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_pos_x,
  input  wire logic [3:0]  in_pos_y,
  input  wire logic [7:0]  in_pos_z,
  input  wire logic [7:0]  in_voxel_type,
  input  wire logic [26:0] in_neighbour_opaque,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_face_id,
  output logic [3:0]       out_quad_x,
  output logic [3:0]       out_quad_y,
  output logic [7:0]       out_quad_z,
  output logic [7:0]       out_quad_type,
  output logic [1:0]       out_occl_corner0,
  output logic [1:0]       out_occl_corner1,
  output logic [1:0]       out_occl_corner2,
  output logic [1:0]       out_occl_corner3,
  output logic             out_split_diag,
  output logic             out_last_quad
);
  import vfcao_pkg::*;

  logic [7:0] empty_code_r;
  vox_t       in_vox;
  logic       s1_valid;
  logic       s1_ready;
  s1_t        s1_data;
  logic       s3_valid;
  logic       s3_ready;
  s3_t        s3_data;

  // Empty type code register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_code_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      empty_code_r <= cfg_data;
    end
  end

  assign in_vox.x     = in_pos_x;
  assign in_vox.y     = in_pos_y;
  assign in_vox.z     = in_pos_z;
  assign in_vox.vtype = in_voxel_type;

  vfcao_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_vox     (in_vox),
    .in_nb      (in_neighbour_opaque),
    .empty_code (empty_code_r),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_data    (s1_data)
  );

  vfcao_occl u_occl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid),
    .in_ready (s1_ready),
    .in_data  (s1_data),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3_data  (s3_data)
  );

  vfcao_serial u_serial (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (s3_valid),
    .in_ready         (s3_ready),
    .in_data          (s3_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_face_id      (out_face_id),
    .out_quad_x       (out_quad_x),
    .out_quad_y       (out_quad_y),
    .out_quad_z       (out_quad_z),
    .out_quad_type    (out_quad_type),
    .out_occl_corner0 (out_occl_corner0),
    .out_occl_corner1 (out_occl_corner1),
    .out_occl_corner2 (out_occl_corner2),
    .out_occl_corner3 (out_occl_corner3),
    .out_split_diag   (out_split_diag),
    .out_last_quad    (out_last_quad)
  );

endmodule

`default_nettype wire

// File: rtl/vfcao_front.sv
`default_nettype none

module vfcao_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire vfcao_pkg::vox_t in_vox,
  input  wire vfcao_pkg::nb_t  in_nb,
  input  wire logic [7:0]    empty_code,
  output logic               s1_valid,
  input  wire logic          s1_ready,
  output vfcao_pkg::s1_t     s1_data
);
  import vfcao_pkg::*;

  logic       s1_valid_r;
  s1_t        s1_data_r;
  face_mask_t exposed;

  // A face is exposed when its direct neighbor is clear and the voxel is solid.
  always_comb begin
    for (int f = 0; f < FACE_NUM; f++) begin
      exposed[f] = !in_nb[DIRECT_BIT[f]] && (in_vox.vtype != empty_code);
    end
  end

  assign in_ready = !s1_valid_r || s1_ready;

  // Stage register; valid travels with the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r.vox     <= in_vox;
      s1_data_r.exposed <= exposed;
      s1_data_r.nb      <= in_nb;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

`default_nettype wire

// File: rtl/vfcao_occl.sv
`default_nettype none

module vfcao_occl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire vfcao_pkg::s1_t in_data,
  output logic             s3_valid,
  input  wire logic        s3_ready,
  output vfcao_pkg::s3_t   s3_data
);
  import vfcao_pkg::*;

  logic       s2_valid_r;
  s2_t        s2_data_r;
  logic       s3_valid_r;
  s3_t        s3_data_r;
  logic       s2_ready;
  all_lv_t    levels;
  face_mask_t split;

  // Corner levels of all six faces in parallel.
  always_comb begin
    for (int f = 0; f < FACE_NUM; f++) begin
      for (int k = 0; k < CORNER_NUM; k++) begin
        levels[f][k] = corner_level(ring_of(in_data.nb, f), k);
      end
    end
  end

  // Split decision from the registered levels.
  always_comb begin
    for (int f = 0; f < FACE_NUM; f++) begin
      split[f] = split_of(s2_data_r.levels[f]);
    end
  end

  assign s2_ready = !s3_valid_r || s3_ready;
  assign in_ready = !s2_valid_r || s2_ready;

  // Level stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_ready) begin
      s2_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s2_data_r.vox     <= in_data.vox;
      s2_data_r.exposed <= in_data.exposed;
      s2_data_r.levels  <= levels;
    end
  end

  // Split stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid_r) begin
      s3_data_r.vox     <= s2_data_r.vox;
      s3_data_r.exposed <= s2_data_r.exposed;
      s3_data_r.levels  <= s2_data_r.levels;
      s3_data_r.split   <= split;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_data  = s3_data_r;

endmodule

`default_nettype wire

// File: rtl/vfcao_serial.sv
`default_nettype none

`include "voxel_face_cull_ambient_occlusion_defines.svh"

module vfcao_serial (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire vfcao_pkg::s3_t in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_face_id,
  output logic [3:0]       out_quad_x,
  output logic [3:0]       out_quad_y,
  output logic [7:0]       out_quad_z,
  output logic [7:0]       out_quad_type,
  output logic [1:0]       out_occl_corner0,
  output logic [1:0]       out_occl_corner1,
  output logic [1:0]       out_occl_corner2,
  output logic [1:0]       out_occl_corner3,
  output logic             out_split_diag,
  output logic             out_last_quad
);
  import vfcao_pkg::*;

  s3_t        hold_r;
  face_mask_t rem_r;
  face_mask_t rem_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  face_t      out_face_r;
  vox_t       out_vox_r;
  face_lv_t   out_lv_r;
  logic       out_split_r;
  logic       out_last_r;

  logic [2:0] pick;
  face_mask_t pick_oh;
  face_mask_t rem_left;
  logic       take;
  logic       hold_free;
  logic       load;

  // Lowest remaining face goes out first.
  always_comb begin
    pick = '0;
    for (int i = FACE_NUM - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        pick = 3'(i);
      end
    end
    pick_oh  = face_mask_t'(1) << pick;
    rem_left = rem_r & ~pick_oh;
  end

  // A voxel with no exposed faces is taken in and dropped right away.
  always_comb begin
    take          = (rem_r != '0) && (!out_valid_r || out_ready);
    hold_free     = (rem_r == '0) || (take && (rem_left == '0));
    load          = in_valid && hold_free;
    rem_nxt       = load ? in_data.exposed : (take ? rem_left : rem_r);
    out_valid_nxt = take || (out_valid_r && !out_ready);
  end

  assign in_ready = hold_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Held voxel and output register.
  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= in_data;
    end
    if (take) begin
      out_face_r  <= face_t'(pick);
      out_vox_r   <= hold_r.vox;
      out_lv_r    <= hold_r.levels[pick];
      out_split_r <= hold_r.split[pick];
      out_last_r  <= (rem_left == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_face_id      = out_face_r;
  assign out_quad_x       = out_vox_r.x;
  assign out_quad_y       = out_vox_r.y;
  assign out_quad_z       = out_vox_r.z;
  assign out_quad_type    = out_vox_r.vtype;
  assign out_occl_corner0 = out_lv_r[0];
  assign out_occl_corner1 = out_lv_r[1];
  assign out_occl_corner2 = out_lv_r[2];
  assign out_occl_corner3 = out_lv_r[3];
  assign out_split_diag   = out_split_r;
  assign out_last_quad    = out_last_r;

  // A quad picked from the held voxel shows up on the output next cycle.
  `VFC_ASSERT(a_take_fills_out, take |=> out_valid_r)
  // Sending the final quad without a new voxel leaves the hold empty.
  `VFC_ASSERT(a_last_empties, (take && rem_left == '0 && !load) |=> (rem_r == '0))
  // A held voxel that cannot send keeps its remaining faces.
  `VFC_ASSERT(a_rem_holds, (rem_r != '0 && !take) |=> $stable(rem_r))
  // Every quad names a real face.
  `VFC_ASSERT(a_face_range, out_valid_r |-> (out_face_r <= FACE_BACK))
  // Reset empties both the hold and the output register.
  `VFC_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_valid_r && rem_r == '0))

endmodule

`default_nettype wire
